// ===== src/normal_angle_colorizer_macros.svh =====
// ---------------------------------------------------------------------------
// normal_angle_colorizer assertion macros
// concurrent checks clocked on clk and disabled while rst_n is low
// ---------------------------------------------------------------------------
`ifndef NORMAL_ANGLE_COLORIZER_MACROS_SVH
`define NORMAL_ANGLE_COLORIZER_MACROS_SVH

// same-cycle implication
`define NAC_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define NAC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/nac_pkg.sv =====
// ---------------------------------------------------------------------------
// nac_pkg
// shared types and constants of the normal angle colorizer
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package nac_pkg;

    localparam int XW = 36;   // cordic x/y width
    localparam int ZW = 20;   // cordic angle width, Q16 radians
    localparam int DW = 25;   // offset width

    localparam int PI_Q16      = 205887;
    localparam int PI3_Q16     = 68629;
    localparam int TWO_PI3_Q16 = 137258;
    localparam int HALF_PI_Q16 = 102944;

    // config register indexes
    typedef enum logic [2:0] {
        REG_ORIGIN_X   = 3'd0,
        REG_ORIGIN_Y   = 3'd1,
        REG_RADIUS_SQ  = 3'd2,
        REG_COLOR_MODE = 3'd3,
        REG_BRIGHTNESS = 3'd4
    } cfg_index_t;

    // per-item data that rides along the cordic chain
    typedef struct packed {
        logic                 vis;
        logic                 zero;
        logic                 ny_neg;
        logic signed [DW-1:0] dx;
        logic signed [DW-1:0] dy;
    } side_t;

    // atan(2^-i) in Q16 radians
    function automatic logic signed [ZW-1:0] atan_of(input int i);
        logic signed [ZW-1:0] a;
        case (i)
            0:       a = 20'sd51472;
            1:       a = 20'sd30386;
            2:       a = 20'sd16055;
            3:       a = 20'sd8150;
            4:       a = 20'sd4091;
            5:       a = 20'sd2047;
            6:       a = 20'sd1024;
            7:       a = 20'sd512;
            8:       a = 20'sd256;
            9:       a = 20'sd128;
            10:      a = 20'sd64;
            11:      a = 20'sd32;
            12:      a = 20'sd16;
            13:      a = 20'sd8;
            14:      a = 20'sd4;
            15:      a = 20'sd2;
            16:      a = 20'sd1;
            default: a = 20'sd0;
        endcase
        return a;
    endfunction

endpackage

// ===== src/nac_cordic_cell.sv =====
// ---------------------------------------------------------------------------
// nac_cordic_cell
// one registered vectoring cordic iteration with its side data
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module nac_cordic_cell #(
    parameter int STAGE = 0
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic signed [nac_pkg::XW-1:0] in_x,
    input  logic signed [nac_pkg::XW-1:0] in_y,
    input  logic signed [nac_pkg::ZW-1:0] in_z,
    input  nac_pkg::side_t                in_side,
    output logic                          out_valid,
    output logic signed [nac_pkg::XW-1:0] out_x,
    output logic signed [nac_pkg::XW-1:0] out_y,
    output logic signed [nac_pkg::ZW-1:0] out_z,
    output nac_pkg::side_t                out_side
);
    import nac_pkg::*;

    localparam logic signed [ZW-1:0] ATAN = atan_of(STAGE);

    logic                 valid_reg;
    logic signed [XW-1:0] x_reg, y_reg, x_next, y_next;
    logic signed [ZW-1:0] z_reg, z_next;
    side_t                side_reg;
    logic signed [XW-1:0] xs, ys;

    assign xs = in_x >>> STAGE;
    assign ys = in_y >>> STAGE;

    // rotate toward the x axis
    always_comb
    begin
        if (!in_y[XW-1])
        begin
            x_next = in_x + ys;
            y_next = in_y - xs;
            z_next = in_z + ATAN;
        end
        else
        begin
            x_next = in_x - ys;
            y_next = in_y + xs;
            z_next = in_z - ATAN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        side_reg <= in_side;
    end

    assign out_valid = valid_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_z     = z_reg;
    assign out_side  = side_reg;

endmodule

// ===== src/nac_color.sv =====
// ---------------------------------------------------------------------------
// nac_color
// angle to gradient color, brightness scale and color matrix pipeline
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module nac_color (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic signed [nac_pkg::ZW-1:0] in_z,
    input  nac_pkg::side_t                in_side,
    input  logic                          color_mode,
    input  logic [12:0]                   brightness,
    output logic                          out_valid,
    output logic                          visible,
    output logic signed [nac_pkg::DW-1:0] offset_x,
    output logic signed [nac_pkg::DW-1:0] offset_y,
    output logic signed [15:0]            red,
    output logic signed [15:0]            green,
    output logic signed [15:0]            blue
);
    import nac_pkg::*;

    localparam logic [15:0] RECIP_PI3     = 16'((64'd1 << 32) / 64'(PI3_Q16));
    localparam logic [15:0] RECIP_TWO_PI3 = 16'((64'd1 << 32) / 64'(TWO_PI3_Q16));

    // rows: red, green, blue; columns: r, g, b
    localparam logic signed [19:0] MAT_COEF [9] = '{
        20'sd212368, -20'sd100739, -20'sd32672,
        -20'sd63521,  20'sd122945,  20'sd2723,
        20'sd3647,   -20'sd13372,   20'sd69292
    };

    logic [6:0] valid_reg;
    side_t      side1_reg, side2_reg, side3_reg, side4_reg, side5_reg, side6_reg;
    logic       tneg1_reg, tneg2_reg;

    // stage 1: clamp angle, form rounded numerator
    logic [17:0]        theta;
    logic signed [19:0] t_val;
    logic               t_neg;
    logic [17:0]        num;
    logic [29:0]        n_next, n1_reg, n2_reg;

    always_comb
    begin
        if (in_side.zero || in_z[ZW-1])
            theta = '0;
        else if (in_z > ZW'(PI_Q16))
            theta = 18'(PI_Q16);
        else
            theta = 18'(in_z);
        t_val = 20'(TWO_PI3_Q16) - $signed({2'b00, theta});
        t_neg = t_val[19];
        num   = t_neg ? 18'(-t_val) : 18'(t_val);
        n_next = {num, 12'b0} + (t_neg ? 30'(PI3_Q16 / 2) : 30'(TWO_PI3_Q16 / 2));
    end

    // stage 2: reciprocal estimate
    logic [45:0] prod2;
    logic [13:0] q0_reg;
    assign prod2 = 46'(n1_reg) * 46'(tneg1_reg ? RECIP_PI3 : RECIP_TWO_PI3);

    // stage 3: one-step correction and clamp
    logic [17:0] den3;
    logic [31:0] qd3, rem3;
    logic [13:0] q3;
    logic [12:0] grad_next, grad_reg;
    logic        tneg3_reg;

    always_comb
    begin
        den3 = tneg2_reg ? 18'(PI3_Q16) : 18'(TWO_PI3_Q16);
        qd3  = 32'(q0_reg) * 32'(den3);
        rem3 = 32'(n2_reg) - qd3;
        q3   = (rem3 >= 32'(den3)) ? q0_reg + 14'd1 : q0_reg;
        grad_next = (q3 > 14'd4096) ? 13'd4096 : 13'(q3);
    end

    // stage 4: color select
    logic [12:0] c_next [3];
    logic [12:0] c_reg  [3];
    logic [12:0] grad_inv;
    assign grad_inv = 13'd4096 - grad_reg;

    always_comb
    begin
        c_next[0] = '0;
        c_next[1] = '0;
        c_next[2] = '0;
        if (!color_mode)
        begin
            c_next[1] = 13'd2048;
            c_next[2] = 13'd4096;
        end
        else if (tneg3_reg)
        begin
            if (side3_reg.ny_neg)
            begin
                c_next[0] = grad_inv;
                c_next[1] = grad_reg;
            end
            else
            begin
                c_next[1] = grad_inv;
                c_next[0] = grad_reg;
            end
        end
        else
        begin
            c_next[2] = grad_reg;
            if (side3_reg.ny_neg)
                c_next[0] = grad_inv;
            else
                c_next[1] = grad_inv;
        end
    end

    // stage 5: brightness scale, stage 6: matrix products
    logic [13:0]        s_reg [3];
    logic signed [34:0] p_reg [9];

    // stage 7: sums, rounding and saturation
    logic signed [36:0] sum7 [3];
    logic signed [20:0] sh7  [3];
    logic signed [15:0] sat7 [3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            sum7[k] = 37'(p_reg[3*k]) + 37'(p_reg[3*k+1]) + 37'(p_reg[3*k+2])
                    + 37'sd32768;
            sh7[k]  = 21'(sum7[k] >>> 16);
            if (sh7[k] > 21'sd32767)
                sat7[k] = 16'sh7fff;
            else if (sh7[k] < -21'sd32768)
                sat7[k] = -16'sh8000;
            else
                sat7[k] = 16'(sh7[k]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= {valid_reg[5:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        side1_reg <= in_side;
        tneg1_reg <= t_neg;
        n1_reg    <= n_next;

        side2_reg <= side1_reg;
        tneg2_reg <= tneg1_reg;
        n2_reg    <= n1_reg;
        q0_reg    <= prod2[45:32];

        side3_reg <= side2_reg;
        tneg3_reg <= tneg2_reg;
        grad_reg  <= grad_next;

        side4_reg <= side3_reg;
        c_reg     <= c_next;

        side5_reg <= side4_reg;
        for (int k = 0; k < 3; k++)
            s_reg[k] <= 14'((26'(c_reg[k]) * 26'(brightness) + 26'd2048) >> 12);

        side6_reg <= side5_reg;
        for (int k = 0; k < 9; k++)
            p_reg[k] <= 35'(MAT_COEF[k]) * 35'($signed({1'b0, s_reg[k % 3]}));

        visible  <= side6_reg.vis;
        offset_x <= side6_reg.dx;
        offset_y <= side6_reg.dy;
        red      <= side6_reg.vis ? sat7[0] : '0;
        green    <= side6_reg.vis ? sat7[1] : '0;
        blue     <= side6_reg.vis ? sat7[2] : '0;
    end

    assign out_valid = valid_reg[6];

endmodule

// ===== src/normal_angle_colorizer.sv =====
// ---------------------------------------------------------------------------
// normal_angle_colorizer
// per-particle offset, visibility and normal-angle color pipeline
// ---------------------------------------------------------------------------
// usage
//   input: pulse start with pos_x/pos_y/normal_x/normal_y; the transfer
//   happens at a clock edge with start high and busy low
//   config: cfg_valid/cfg_ready write channel, cfg_index picks the register
//   (0 origin x, 1 origin y, 2 radius_limit_sq, 3 color_mode, 4 brightness),
//   other indexes are dropped; write only while no particle is in flight
//   result: done is high for exactly one cycle per particle with visible,
//   offset_x/offset_y and red/green/blue; the receiver cannot stall it
//   throughput: one particle per clock, back to back
//   path from input transfer to done: input register, square/cordic
//   setup, one cell per cordic stage, seven color stages; the cordic
//   cell row sets the length
//   reset: rst_n low clears all valid flags and restores register defaults;
//   busy is high during reset and the cycle after
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "normal_angle_colorizer_macros.svh"

module normal_angle_colorizer #(
    parameter int CORDIC_STAGES = 14
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // particle input
    input  logic                          start,
    output logic                          busy,
    input  logic signed [23:0]            pos_x,
    input  logic signed [23:0]            pos_y,
    input  logic signed [15:0]            normal_x,
    input  logic signed [15:0]            normal_y,
    // config write channel
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [2:0]                    cfg_index,
    input  logic [49:0]                   cfg_data,
    // result
    output logic                          done,
    output logic                          visible,
    output logic signed [nac_pkg::DW-1:0] offset_x,
    output logic signed [nac_pkg::DW-1:0] offset_y,
    output logic signed [15:0]            red,
    output logic signed [15:0]            green,
    output logic signed [15:0]            blue
);
    import nac_pkg::*;

    localparam int LAT = CORDIC_STAGES + 9;

    // config registers
    logic                 busy_reg;
    logic signed [23:0]   origin_x_reg, origin_y_reg;
    logic [49:0]          radius_sq_reg;
    logic                 color_mode_reg;
    logic [12:0]          brightness_reg;
    logic                 in_xfer;

    assign busy      = busy_reg;
    assign cfg_ready = !busy_reg;
    assign in_xfer   = start && !busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b1;
            origin_x_reg   <= '0;
            origin_y_reg   <= '0;
            radius_sq_reg  <= 50'd16384000000;
            color_mode_reg <= 1'b0;
            brightness_reg <= 13'd3072;
        end
        else
        begin
            busy_reg <= 1'b0;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_ORIGIN_X:   origin_x_reg   <= cfg_data[23:0];
                    REG_ORIGIN_Y:   origin_y_reg   <= cfg_data[23:0];
                    REG_RADIUS_SQ:  radius_sq_reg  <= cfg_data;
                    REG_COLOR_MODE: color_mode_reg <= cfg_data[0];
                    REG_BRIGHTNESS: brightness_reg <= cfg_data[12:0];
                    default:        ;
                endcase
            end
        end
    end

    // stage a: offsets and normal capture
    logic                 a_valid_reg;
    logic signed [DW-1:0] dx_reg, dy_reg;
    logic signed [15:0]   nx_reg, ny_reg;

    // stage b: squares and cordic start vector
    logic                 b_valid_reg;
    logic [48:0]          sqx_reg, sqy_reg;
    logic signed [XW-1:0] x0_reg, y0_reg;
    logic signed [ZW-1:0] z0_reg;
    side_t                b_side_reg;

    logic signed [49:0]   sqx_full, sqy_full;
    logic [16:0]          ax, ay;
    logic signed [XW-1:0] x0_next, y0_next;
    logic signed [ZW-1:0] z0_next;

    assign sqx_full = dx_reg * dx_reg;
    assign sqy_full = dy_reg * dy_reg;

    // fold the normal into the right half plane with |ny|
    always_comb
    begin
        ax = nx_reg[15] ? 17'(-$signed({nx_reg[15], nx_reg})) : 17'(nx_reg);
        ay = ny_reg[15] ? 17'(-$signed({ny_reg[15], ny_reg})) : 17'(ny_reg);
        if (nx_reg[15])
        begin
            x0_next = $signed({{(XW - 33){1'b0}}, ay, 16'b0});
            y0_next = $signed({{(XW - 33){1'b0}}, ax, 16'b0});
            z0_next = ZW'(HALF_PI_Q16);
        end
        else
        begin
            x0_next = $signed({{(XW - 33){1'b0}}, ax, 16'b0});
            y0_next = $signed({{(XW - 33){1'b0}}, ay, 16'b0});
            z0_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= in_xfer;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        dx_reg <= DW'(pos_x) - DW'(origin_x_reg);
        dy_reg <= DW'(pos_y) - DW'(origin_y_reg);
        nx_reg <= normal_x;
        ny_reg <= normal_y;

        sqx_reg           <= sqx_full[48:0];
        sqy_reg           <= sqy_full[48:0];
        x0_reg            <= x0_next;
        y0_reg            <= y0_next;
        z0_reg            <= z0_next;
        b_side_reg.vis    <= 1'b0;
        b_side_reg.zero   <= (nx_reg == '0) && (ny_reg == '0);
        b_side_reg.ny_neg <= ny_reg[15];
        b_side_reg.dx     <= dx_reg;
        b_side_reg.dy     <= dy_reg;
    end

    // visibility joins the side data at the head of the cell row
    side_t head_side;
    always_comb
    begin
        head_side     = b_side_reg;
        head_side.vis = ({1'b0, sqx_reg} + {1'b0, sqy_reg}) < radius_sq_reg;
    end

    // cordic cell row
    logic                 c_valid [CORDIC_STAGES + 1];
    logic signed [XW-1:0] c_x     [CORDIC_STAGES + 1];
    logic signed [XW-1:0] c_y     [CORDIC_STAGES + 1];
    logic signed [ZW-1:0] c_z     [CORDIC_STAGES + 1];
    side_t                c_side  [CORDIC_STAGES + 1];

    assign c_valid[0] = b_valid_reg;
    assign c_x[0]     = x0_reg;
    assign c_y[0]     = y0_reg;
    assign c_z[0]     = z0_reg;
    assign c_side[0]  = head_side;

    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_cell
        nac_cordic_cell #(
            .STAGE (i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (c_valid[i]),
            .in_x      (c_x[i]),
            .in_y      (c_y[i]),
            .in_z      (c_z[i]),
            .in_side   (c_side[i]),
            .out_valid (c_valid[i + 1]),
            .out_x     (c_x[i + 1]),
            .out_y     (c_y[i + 1]),
            .out_z     (c_z[i + 1]),
            .out_side  (c_side[i + 1])
        );
    end

    // gradient, brightness and color matrix
    nac_color u_color (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (c_valid[CORDIC_STAGES]),
        .in_z       (c_z[CORDIC_STAGES]),
        .in_side    (c_side[CORDIC_STAGES]),
        .color_mode (color_mode_reg),
        .brightness (brightness_reg),
        .out_valid  (done),
        .visible    (visible),
        .offset_x   (offset_x),
        .offset_y   (offset_y),
        .red        (red),
        .green      (green),
        .blue       (blue)
    );

    // checks
    logic mode_wr;
    assign mode_wr = cfg_valid && cfg_ready && (cfg_index == REG_COLOR_MODE);

    `NAC_ASSERT_IMPL(a_hidden_black, done && !visible, {red, green, blue} == '0, "hidden lit")
    `NAC_ASSERT_IMPL(a_latency, done, $past(in_xfer, LAT), "result strobe without transfer")
    `NAC_ASSERT_NEXT(a_mode_write, mode_wr, color_mode_reg == $past(cfg_data[0]), "mode lost")

endmodule
